>>> hw/rtl/imucd_pkg.sv
// Shared types, constants and register codes of the IMU crash detector.
package imucd_pkg;

    localparam int SampleW   = 16;
    localparam int TimeW     = 32;
    localparam int MagW      = 32;
    localparam int CosW      = 17;
    localparam int WinW      = 16;
    localparam int SqW       = 31;                 // one square of a 16-bit sample
    localparam int ProdW     = CosW + MagW;        // cos^2 times floored magnitude
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 32;
    localparam int QueueDepth = 2;

    localparam logic [MagW-1:0] AccelFloorSq = MagW'(268);

    localparam logic [MagW-1:0] ImpactReset   = 32'd268435456;
    localparam logic [MagW-1:0] RotationReset = 32'd1072562500;
    localparam logic [CosW-1:0] TiltCosReset  = 17'd7666;
    localparam logic [WinW-1:0] ConfirmReset  = 16'd10000;
    localparam logic [WinW-1:0] StreakReset   = 16'd5000;
    localparam logic [WinW-1:0] GraceReset    = 16'd30000;
    localparam logic [WinW-1:0] BlinkReset    = 16'd300;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_IMPACT   = 3'd0,
        CFG_ROTATION = 3'd1,
        CFG_TILT_COS = 3'd2,
        CFG_CONFIRM  = 3'd3,
        CFG_STREAK   = 3'd4,
        CFG_GRACE    = 3'd5,
        CFG_BLINK    = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_MONITOR = 2'd0,
        MODE_CONFIRM = 2'd1,
        MODE_GRACE   = 2'd2
    } t_mode;

    // Front end sequencer: three squaring steps, tilt product, hand-off.
    typedef enum logic [2:0] {
        STEP_X    = 3'd0,
        STEP_Y    = 3'd1,
        STEP_Z    = 3'd2,
        STEP_PROD = 3'd3,
        STEP_PUSH = 3'd4
    } t_step;

    typedef struct packed {
        logic [MagW-1:0] impact_mag_sq;
        logic [MagW-1:0] rotation_mag_sq;
        logic [CosW-1:0] tilt_cos_sq_q16;
        logic [WinW-1:0] confirm_win_ms;
        logic [WinW-1:0] streak_hold_ms;
        logic [WinW-1:0] grace_win_ms;
        logic [WinW-1:0] blink_period_ms;
    } t_cfg;

    // Classified sample handed from front end to mode machine.
    typedef struct packed {
        logic             impact;
        logic             rotating;
        logic             tilted;
        logic [TimeW-1:0] now_ms;
    } t_cls;

    typedef struct packed {
        logic [1:0] mode;
        logic       led_on;
        logic       beeper_on;
        logic       snapshot_pulse;
        logic       alert_pulse;
    } t_res;

endpackage

>>> hw/rtl/imu_crash_detector.sv
// Top level of the IMU crash detector: config registers, front end, queue, mode machine.
//
// Usage:
//   Samples go in through a queue-like port: a beat is taken at a clock edge
//   with push high and full low. Each sample carries six raw 16-bit IMU axes
//   and a wrapping millisecond timestamp. Results come out the same way: the
//   oldest result sits on o_mode, o_led_on, o_beeper_on, o_snapshot_pulse and
//   o_alert_pulse while empty is low and leaves at an edge with pop high.
//   Exactly one result per sample, in order.
//   Registers are written on the cfg channel (index, data); it is always ready
//   and should be written only while no sample is in flight.
// Timing:
//   The front end works on one sample at a time: squaring steps for x, y and z on
//   two shared 16x16 squarers (accel and gyro lanes), the 17x32 tilt product, then
//   a step that compares and queues the classified beat, waiting while the queue is
//   full; a new sample is taken as the last one is queued. The mode machine takes a
//   queued beat when the result register is empty or being popped, and registers it.
//   If pop stays low the result register holds, the queue fills and full rises.
// Reset:
//   Synchronous, active low. Registers return to defaults, mode to monitor,
//   LED and buzzer off, queue and result register empty.
module imu_crash_detector #(
    parameter int QUEUE_DEPTH = imucd_pkg::QueueDepth
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [imucd_pkg::SampleW-1:0] i_accel_x,
    input  logic signed [imucd_pkg::SampleW-1:0] i_accel_y,
    input  logic signed [imucd_pkg::SampleW-1:0] i_accel_z,
    input  logic signed [imucd_pkg::SampleW-1:0] i_gyro_x,
    input  logic signed [imucd_pkg::SampleW-1:0] i_gyro_y,
    input  logic signed [imucd_pkg::SampleW-1:0] i_gyro_z,
    input  logic [imucd_pkg::TimeW-1:0]          i_now_ms,
    output logic                                empty,
    input  logic                                pop,
    output logic [1:0]                          o_mode,
    output logic                                o_led_on,
    output logic                                o_beeper_on,
    output logic                                o_snapshot_pulse,
    output logic                                o_alert_pulse,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [imucd_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [imucd_pkg::CfgDataW-1:0]       i_cfg_data
);

    imucd_pkg::t_cfg r_cfg;
    imucd_pkg::t_cls front_data, q_data;
    imucd_pkg::t_res res;
    logic            front_push, q_ready, q_valid, q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.impact_mag_sq   <= imucd_pkg::ImpactReset;
            r_cfg.rotation_mag_sq <= imucd_pkg::RotationReset;
            r_cfg.tilt_cos_sq_q16 <= imucd_pkg::TiltCosReset;
            r_cfg.confirm_win_ms  <= imucd_pkg::ConfirmReset;
            r_cfg.streak_hold_ms  <= imucd_pkg::StreakReset;
            r_cfg.grace_win_ms    <= imucd_pkg::GraceReset;
            r_cfg.blink_period_ms <= imucd_pkg::BlinkReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                imucd_pkg::CFG_IMPACT:   r_cfg.impact_mag_sq   <= i_cfg_data;
                imucd_pkg::CFG_ROTATION: r_cfg.rotation_mag_sq <= i_cfg_data;
                imucd_pkg::CFG_TILT_COS:
                    r_cfg.tilt_cos_sq_q16 <= i_cfg_data[imucd_pkg::CosW-1:0];
                imucd_pkg::CFG_CONFIRM:
                    r_cfg.confirm_win_ms <= i_cfg_data[imucd_pkg::WinW-1:0];
                imucd_pkg::CFG_STREAK:
                    r_cfg.streak_hold_ms <= i_cfg_data[imucd_pkg::WinW-1:0];
                imucd_pkg::CFG_GRACE:
                    r_cfg.grace_win_ms <= i_cfg_data[imucd_pkg::WinW-1:0];
                imucd_pkg::CFG_BLINK:
                    r_cfg.blink_period_ms <= i_cfg_data[imucd_pkg::WinW-1:0];
                default: ;
            endcase
        end
    end

    imucd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_accel_x (i_accel_x),
        .i_accel_y (i_accel_y),
        .i_accel_z (i_accel_z),
        .i_gyro_x  (i_gyro_x),
        .i_gyro_y  (i_gyro_y),
        .i_gyro_z  (i_gyro_z),
        .i_now_ms  (i_now_ms),
        .i_cfg     (r_cfg),
        .o_q_push  (front_push),
        .i_q_ready (q_ready),
        .o_q_data  (front_data)
    );

    imucd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_data),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    imucd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_cfg     (r_cfg),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_res     (res)
    );

    assign o_mode           = res.mode;
    assign o_led_on         = res.led_on;
    assign o_beeper_on      = res.beeper_on;
    assign o_snapshot_pulse = res.snapshot_pulse;
    assign o_alert_pulse    = res.alert_pulse;

endmodule

>>> hw/rtl/imucd_front.sv
// Front end: squares the six axes on two shared squarers and classifies the sample.
module imucd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic signed [imucd_pkg::SampleW-1:0] i_accel_x,
    input  logic signed [imucd_pkg::SampleW-1:0] i_accel_y,
    input  logic signed [imucd_pkg::SampleW-1:0] i_accel_z,
    input  logic signed [imucd_pkg::SampleW-1:0] i_gyro_x,
    input  logic signed [imucd_pkg::SampleW-1:0] i_gyro_y,
    input  logic signed [imucd_pkg::SampleW-1:0] i_gyro_z,
    input  logic [imucd_pkg::TimeW-1:0]          i_now_ms,
    input  imucd_pkg::t_cfg                      i_cfg,
    output logic                                o_q_push,
    input  logic                                i_q_ready,
    output imucd_pkg::t_cls                      o_q_data
);

    logic                                r_busy, n_busy;
    imucd_pkg::t_step                    r_step, n_step;
    logic signed [imucd_pkg::SampleW-1:0] r_ax, r_ay, r_az, r_gx, r_gy, r_gz;
    logic [imucd_pkg::TimeW-1:0]          r_now;
    logic [imucd_pkg::MagW-1:0]           r_a2, r_g2;
    logic [imucd_pkg::SqW-1:0]            r_az2;
    logic [imucd_pkg::ProdW-1:0]          r_prod;

    logic signed [imucd_pkg::SampleW-1:0] sel_a, sel_g;
    logic signed [2*imucd_pkg::SampleW-1:0] sq_a, sq_g;
    logic [imucd_pkg::MagW-1:0]           denom;
    logic                                accept, push_done;

    assign push_done = r_busy && (r_step == imucd_pkg::STEP_PUSH) && i_q_ready;
    assign o_full    = r_busy && !push_done;
    assign accept    = i_push && !o_full;

    always_comb begin
        case (r_step)
            imucd_pkg::STEP_X: begin sel_a = r_ax; sel_g = r_gx; end
            imucd_pkg::STEP_Y: begin sel_a = r_ay; sel_g = r_gy; end
            default:           begin sel_a = r_az; sel_g = r_gz; end
        endcase
    end

    assign sq_a  = sel_a * sel_a;
    assign sq_g  = sel_g * sel_g;
    assign denom = (r_a2 > imucd_pkg::AccelFloorSq) ? r_a2 : imucd_pkg::AccelFloorSq;

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (r_busy) begin
            unique case (r_step)
                imucd_pkg::STEP_X:    n_step = imucd_pkg::STEP_Y;
                imucd_pkg::STEP_Y:    n_step = imucd_pkg::STEP_Z;
                imucd_pkg::STEP_Z:    n_step = imucd_pkg::STEP_PROD;
                imucd_pkg::STEP_PROD: n_step = imucd_pkg::STEP_PUSH;
                imucd_pkg::STEP_PUSH: n_step = imucd_pkg::STEP_PUSH;
                default:              n_step = imucd_pkg::STEP_X;
            endcase
        end
        if (push_done) begin
            n_busy = 1'b0;
        end
        if (accept) begin
            n_busy = 1'b1;
            n_step = imucd_pkg::STEP_X;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= imucd_pkg::STEP_X;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax  <= i_accel_x;
            r_ay  <= i_accel_y;
            r_az  <= i_accel_z;
            r_gx  <= i_gyro_x;
            r_gy  <= i_gyro_y;
            r_gz  <= i_gyro_z;
            r_now <= i_now_ms;
        end
        if (r_busy) begin
            case (r_step) inside
                imucd_pkg::STEP_X: begin
                    r_a2 <= imucd_pkg::MagW'(sq_a[imucd_pkg::SqW-1:0]);
                    r_g2 <= imucd_pkg::MagW'(sq_g[imucd_pkg::SqW-1:0]);
                end
                imucd_pkg::STEP_Y, imucd_pkg::STEP_Z: begin
                    r_a2 <= r_a2 + imucd_pkg::MagW'(sq_a[imucd_pkg::SqW-1:0]);
                    r_g2 <= r_g2 + imucd_pkg::MagW'(sq_g[imucd_pkg::SqW-1:0]);
                    if (r_step == imucd_pkg::STEP_Z) begin
                        r_az2 <= sq_a[imucd_pkg::SqW-1:0];
                    end
                end
                imucd_pkg::STEP_PROD: begin
                    r_prod <= {{imucd_pkg::MagW{1'b0}}, i_cfg.tilt_cos_sq_q16}
                            * {{imucd_pkg::CosW{1'b0}}, denom};
                end
                default: ;
            endcase
        end
    end

    // tilt test: az^2 * 2^16 < cos^2 * max(A^2, floor), exact
    assign o_q_push        = r_busy && (r_step == imucd_pkg::STEP_PUSH);
    assign o_q_data.impact   = r_a2 > i_cfg.impact_mag_sq;
    assign o_q_data.rotating = r_g2 > i_cfg.rotation_mag_sq;
    assign o_q_data.tilted   = imucd_pkg::ProdW'({r_az2, 16'h0000}) < r_prod;
    assign o_q_data.now_ms   = r_now;

endmodule

>>> hw/rtl/imucd_fifo.sv
// Small flop queue of classified samples between front end and mode machine.
module imucd_fifo #(
    parameter int DEPTH = imucd_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  imucd_pkg::t_cls i_data,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_pop,
    output imucd_pkg::t_cls o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);

    imucd_pkg::t_cls   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push, do_pop;

    assign o_ready = r_cnt != FullCnt;
    assign o_valid = r_cnt != '0;
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LastPtr) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LastPtr) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> hw/rtl/imucd_back.sv
// Back end: monitor/confirm/grace mode machine and the result register.
module imucd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  imucd_pkg::t_cls i_q_data,
    output logic            o_q_pop,
    input  imucd_pkg::t_cfg i_cfg,
    output logic            o_empty,
    input  logic            i_pop,
    output imucd_pkg::t_res o_res
);

    imucd_pkg::t_mode             r_mode, n_mode;
    logic [imucd_pkg::TimeW-1:0]  r_confirm_start, n_confirm_start;
    logic [imucd_pkg::TimeW-1:0]  r_streak_start, n_streak_start;
    logic [imucd_pkg::TimeW-1:0]  r_grace_start, n_grace_start;
    logic [imucd_pkg::TimeW-1:0]  r_last_toggle, n_last_toggle;
    logic                         r_streak_valid, n_streak_valid;
    logic                         r_led, n_led;
    logic                         r_buzzer, n_buzzer;
    logic                         r_out_valid;
    imucd_pkg::t_res              r_out;
    logic                         snap, alert, step;
    logic [imucd_pkg::TimeW-1:0]  now, streak_base;

    assign step    = i_q_valid && (!r_out_valid || i_pop);
    assign o_q_pop = step;
    assign o_empty = !r_out_valid;
    assign o_res   = r_out;
    assign now     = i_q_data.now_ms;

    always_comb begin
        n_mode          = r_mode;
        n_confirm_start = r_confirm_start;
        n_streak_start  = r_streak_start;
        n_grace_start   = r_grace_start;
        n_last_toggle   = r_last_toggle;
        n_streak_valid  = r_streak_valid;
        n_led           = r_led;
        n_buzzer        = r_buzzer;
        snap            = 1'b0;
        alert           = 1'b0;
        streak_base     = r_streak_valid ? r_streak_start : now;
        unique case (r_mode)
            imucd_pkg::MODE_MONITOR: begin
                if (i_q_data.impact && i_q_data.rotating) begin
                    n_confirm_start = now;
                    n_streak_valid  = 1'b0;
                    n_mode          = imucd_pkg::MODE_CONFIRM;
                end
            end
            imucd_pkg::MODE_CONFIRM: begin
                if (i_q_data.tilted) begin
                    n_streak_start = streak_base;
                    n_streak_valid = 1'b1;
                    if (now - streak_base >= {16'h0000, i_cfg.streak_hold_ms}) begin
                        snap          = 1'b1;
                        n_grace_start = now;
                        n_last_toggle = now;
                        n_led         = 1'b0;
                        n_buzzer      = 1'b0;
                        n_mode        = imucd_pkg::MODE_GRACE;
                    end
                end else begin
                    n_streak_valid = 1'b0;
                end
                // window timeout wins even over a snapshot on this beat
                if (now - r_confirm_start >= {16'h0000, i_cfg.confirm_win_ms}) begin
                    n_mode = imucd_pkg::MODE_MONITOR;
                end
            end
            imucd_pkg::MODE_GRACE: begin
                if (now - r_last_toggle >= {16'h0000, i_cfg.blink_period_ms}) begin
                    n_last_toggle = now;
                    n_led         = !r_led;
                end
                n_buzzer = 1'b1;
                if (now - r_grace_start >= {16'h0000, i_cfg.grace_win_ms}) begin
                    n_led    = 1'b0;
                    n_buzzer = 1'b0;
                    alert    = 1'b1;
                    n_mode   = imucd_pkg::MODE_MONITOR;
                end
            end
            default: begin
                n_mode = imucd_pkg::MODE_MONITOR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= imucd_pkg::MODE_MONITOR;
            r_confirm_start <= '0;
            r_streak_start  <= '0;
            r_grace_start   <= '0;
            r_last_toggle   <= '0;
            r_streak_valid  <= 1'b0;
            r_led           <= 1'b0;
            r_buzzer        <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (step) begin
                r_mode          <= n_mode;
                r_confirm_start <= n_confirm_start;
                r_streak_start  <= n_streak_start;
                r_grace_start   <= n_grace_start;
                r_last_toggle   <= n_last_toggle;
                r_streak_valid  <= n_streak_valid;
                r_led           <= n_led;
                r_buzzer        <= n_buzzer;
                r_out_valid     <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.mode           <= n_mode;
            r_out.led_on         <= n_led;
            r_out.beeper_on      <= n_buzzer;
            r_out.snapshot_pulse <= snap;
            r_out.alert_pulse    <= alert;
        end
    end

endmodule

>>> tb/imu_crash_checker.sv
// Checker for the IMU crash detector: models the mode machine and compares every result beat.
module imu_crash_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    input  logic                                 full,
    input  logic signed [imucd_pkg::SampleW-1:0] i_accel_x,
    input  logic signed [imucd_pkg::SampleW-1:0] i_accel_y,
    input  logic signed [imucd_pkg::SampleW-1:0] i_accel_z,
    input  logic signed [imucd_pkg::SampleW-1:0] i_gyro_x,
    input  logic signed [imucd_pkg::SampleW-1:0] i_gyro_y,
    input  logic signed [imucd_pkg::SampleW-1:0] i_gyro_z,
    input  logic [imucd_pkg::TimeW-1:0]          i_now_ms,
    input  logic                                 empty,
    input  logic                                 pop,
    input  logic [1:0]                           o_mode,
    input  logic                                 o_led_on,
    input  logic                                 o_beeper_on,
    input  logic                                 o_snapshot_pulse,
    input  logic                                 o_alert_pulse,
    input  logic                                 i_cfg_valid,
    input  logic                                 o_cfg_ready,
    input  logic [imucd_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [imucd_pkg::CfgDataW-1:0]        i_cfg_data,
    output int                                   o_mismatches,
    output int                                   o_outstanding,
    output int                                   o_snapshots,
    output int                                   o_alerts
);

    imucd_pkg::t_cfg             regs;
    imucd_pkg::t_mode            fsm_mode;
    logic [imucd_pkg::TimeW-1:0] confirm_t0, streak_t0, grace_t0, toggle_t0;
    logic                        streak_on, led_lvl, buzz_lvl;
    imucd_pkg::t_res             alarm_states_due[$];
    int                          mismatches = 0;
    int                          snapshots = 0;
    int                          alerts = 0;

    function automatic void load_defaults();
        regs.impact_mag_sq   = imucd_pkg::ImpactReset;
        regs.rotation_mag_sq = imucd_pkg::RotationReset;
        regs.tilt_cos_sq_q16 = imucd_pkg::TiltCosReset;
        regs.confirm_win_ms  = imucd_pkg::ConfirmReset;
        regs.streak_hold_ms  = imucd_pkg::StreakReset;
        regs.grace_win_ms    = imucd_pkg::GraceReset;
        regs.blink_period_ms = imucd_pkg::BlinkReset;
        fsm_mode   = imucd_pkg::MODE_MONITOR;
        confirm_t0 = '0;
        streak_t0  = '0;
        grace_t0   = '0;
        toggle_t0  = '0;
        streak_on  = 1'b0;
        led_lvl    = 1'b0;
        buzz_lvl   = 1'b0;
    endfunction

    function automatic void write_reg(input logic [imucd_pkg::CfgIdxW-1:0] idx,
                                      input logic [imucd_pkg::CfgDataW-1:0] val);
        case (imucd_pkg::t_cfg_idx'(idx))
            imucd_pkg::CFG_IMPACT:   regs.impact_mag_sq   = val;
            imucd_pkg::CFG_ROTATION: regs.rotation_mag_sq = val;
            imucd_pkg::CFG_TILT_COS: regs.tilt_cos_sq_q16 = val[imucd_pkg::CosW-1:0];
            imucd_pkg::CFG_CONFIRM:  regs.confirm_win_ms  = val[imucd_pkg::WinW-1:0];
            imucd_pkg::CFG_STREAK:   regs.streak_hold_ms  = val[imucd_pkg::WinW-1:0];
            imucd_pkg::CFG_GRACE:    regs.grace_win_ms    = val[imucd_pkg::WinW-1:0];
            imucd_pkg::CFG_BLINK:    regs.blink_period_ms = val[imucd_pkg::WinW-1:0];
            default: ;
        endcase
    endfunction

    // Advances the modeled mode machine by one sample and returns the alarm outputs.
    function automatic imucd_pkg::t_res step_crash_fsm(
        input logic signed [imucd_pkg::SampleW-1:0] ax, ay, az,
        input logic signed [imucd_pkg::SampleW-1:0] gx, gy, gz,
        input logic [imucd_pkg::TimeW-1:0] stamp);
        longint sax, say, saz, sgx, sgy, sgz;
        longint unsigned acc_sq, gyr_sq, az_sq, denom;
        logic hit, spin, tilt;
        logic [imucd_pkg::TimeW-1:0] in_confirm;
        imucd_pkg::t_res r;
        sax = ax; say = ay; saz = az;
        sgx = gx; sgy = gy; sgz = gz;
        acc_sq = sax * sax + say * say + saz * saz;
        gyr_sq = sgx * sgx + sgy * sgy + sgz * sgz;
        az_sq  = saz * saz;
        denom  = (acc_sq > 64'(imucd_pkg::AccelFloorSq)) ? acc_sq
                                                         : 64'(imucd_pkg::AccelFloorSq);
        hit    = acc_sq > 64'(regs.impact_mag_sq);
        spin   = gyr_sq > 64'(regs.rotation_mag_sq);
        // exact integer stand-in for acos: az^2 / |a|^2 below cos^2 of the limit
        tilt   = (az_sq << 16) < 64'(regs.tilt_cos_sq_q16) * denom;
        r = '0;
        case (fsm_mode)
            imucd_pkg::MODE_MONITOR: begin
                if (hit && spin) begin
                    confirm_t0 = stamp;
                    streak_on  = 1'b0;
                    fsm_mode   = imucd_pkg::MODE_CONFIRM;
                end
            end
            imucd_pkg::MODE_CONFIRM: begin
                in_confirm = stamp - confirm_t0;
                if (tilt) begin
                    if (!streak_on) begin
                        streak_t0 = stamp;
                        streak_on = 1'b1;
                    end
                    if (32'(stamp - streak_t0) >= 32'(regs.streak_hold_ms)) begin
                        r.snapshot_pulse = 1'b1;
                        grace_t0  = stamp;
                        toggle_t0 = stamp;
                        led_lvl   = 1'b0;
                        buzz_lvl  = 1'b0;
                        fsm_mode  = imucd_pkg::MODE_GRACE;
                    end
                end else begin
                    streak_on = 1'b0;
                end
                // window expiry wins even over a fresh snapshot
                if (in_confirm >= 32'(regs.confirm_win_ms))
                    fsm_mode = imucd_pkg::MODE_MONITOR;
            end
            imucd_pkg::MODE_GRACE: begin
                if (32'(stamp - toggle_t0) >= 32'(regs.blink_period_ms)) begin
                    toggle_t0 = stamp;
                    led_lvl   = !led_lvl;
                end
                buzz_lvl = 1'b1;
                if (32'(stamp - grace_t0) >= 32'(regs.grace_win_ms)) begin
                    led_lvl       = 1'b0;
                    buzz_lvl      = 1'b0;
                    r.alert_pulse = 1'b1;
                    fsm_mode      = imucd_pkg::MODE_MONITOR;
                end
            end
            default: fsm_mode = imucd_pkg::MODE_MONITOR;
        endcase
        r.mode      = fsm_mode;
        r.led_on    = led_lvl;
        r.beeper_on = buzz_lvl;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [1:0] want,
                                          input logic [1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        imucd_pkg::t_res want;
        if (!i_rst_n) begin
            load_defaults();
            alarm_states_due.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                write_reg(i_cfg_index, i_cfg_data);
            if (pop && !empty) begin
                if (alarm_states_due.size() == 0) begin
                    $error("result beat with nothing expected: mode %0d", o_mode);
                    mismatches++;
                end else begin
                    want = alarm_states_due.pop_front();
                    compare_field("mode", want.mode, o_mode);
                    compare_field("led_on", 2'(want.led_on), 2'(o_led_on));
                    compare_field("beeper_on", 2'(want.beeper_on), 2'(o_beeper_on));
                    compare_field("snapshot_pulse", 2'(want.snapshot_pulse),
                                  2'(o_snapshot_pulse));
                    compare_field("alert_pulse", 2'(want.alert_pulse), 2'(o_alert_pulse));
                end
            end
            if (push && !full) begin
                want = step_crash_fsm(i_accel_x, i_accel_y, i_accel_z,
                                      i_gyro_x, i_gyro_y, i_gyro_z, i_now_ms);
                if (want.snapshot_pulse) snapshots++;
                if (want.alert_pulse) alerts++;
                alarm_states_due.push_back(want);
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= alarm_states_due.size();
        o_snapshots   <= snapshots;
        o_alerts      <= alerts;
    end

endmodule

>>> tb/imu_crash_detector_test.sv
// Testbench top for the IMU crash detector: clock, reset, samples, register writes, verdict.
module imu_crash_detector_test;

    typedef struct packed {
        logic signed [imucd_pkg::SampleW-1:0] ax, ay, az, gx, gy, gz;
        logic [imucd_pkg::TimeW-1:0]          stamp;
    } t_imu_sample;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 push = 1'b0;
    logic                                 pop = 1'b0;
    logic signed [imucd_pkg::SampleW-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
    logic signed [imucd_pkg::SampleW-1:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
    logic [imucd_pkg::TimeW-1:0]          now_ms = '0;
    logic                                 cfg_valid = 1'b0;
    imucd_pkg::t_cfg_idx                  cfg_index = imucd_pkg::CFG_IMPACT;
    logic [imucd_pkg::CfgDataW-1:0]       cfg_data = '0;

    wire        full, empty, cfg_ready;
    wire [1:0]  mode;
    wire        led_on, beeper_on, snapshot_pulse, alert_pulse;
    int         mismatches, outstanding, snapshots, alerts;

    int snd_idle_pct = 25;
    int rcv_idle_pct = 74;
    int hold_asks = 0;
    int samples_sent = 0;
    int settings_used = 1;

    always #10 clk = ~clk;

    imu_crash_detector DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .push             (push),
        .full             (full),
        .i_accel_x        (accel_x),
        .i_accel_y        (accel_y),
        .i_accel_z        (accel_z),
        .i_gyro_x         (gyro_x),
        .i_gyro_y         (gyro_y),
        .i_gyro_z         (gyro_z),
        .i_now_ms         (now_ms),
        .empty            (empty),
        .pop              (pop),
        .o_mode           (mode),
        .o_led_on         (led_on),
        .o_beeper_on      (beeper_on),
        .o_snapshot_pulse (snapshot_pulse),
        .o_alert_pulse    (alert_pulse),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    imu_crash_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .push             (push),
        .full             (full),
        .i_accel_x        (accel_x),
        .i_accel_y        (accel_y),
        .i_accel_z        (accel_z),
        .i_gyro_x         (gyro_x),
        .i_gyro_y         (gyro_y),
        .i_gyro_z         (gyro_z),
        .i_now_ms         (now_ms),
        .empty            (empty),
        .pop              (pop),
        .o_mode           (mode),
        .o_led_on         (led_on),
        .o_beeper_on      (beeper_on),
        .o_snapshot_pulse (snapshot_pulse),
        .o_alert_pulse    (alert_pulse),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding),
        .o_snapshots      (snapshots),
        .o_alerts         (alerts)
    );

    initial begin
        #(20 * 400_000);
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: random pop, plus long hold-offs on request.
    initial begin : result_side
        int seen;
        int left;
        seen = 0;
        left = 0;
        forever begin
            @(posedge clk);
            if (hold_asks != seen) begin
                seen = hold_asks;
                left = 300;
            end
            if (left > 0) begin
                left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    function automatic t_imu_sample mk(input int ax, ay, az, gx, gy, gz,
                                       input logic [imucd_pkg::TimeW-1:0] stamp);
        t_imu_sample s;
        s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
        s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
        s.stamp = stamp;
        return s;
    endfunction

    function automatic int big_axis();
        int v;
        v = $urandom_range(28000, 32768);
        return $urandom_range(1) ? -v : ((v > 32767) ? 32767 : v);
    endfunction

    function automatic int spread(input int k);
        return $urandom_range(0, 2 * k) - k;
    endfunction

    function automatic t_imu_sample hit_sample(input logic [imucd_pkg::TimeW-1:0] stamp);
        return mk(big_axis(), big_axis(), big_axis(), big_axis(), big_axis(), big_axis(),
                  stamp);
    endfunction

    // Gravity mostly across x: lying on the side.
    function automatic t_imu_sample tilt_sample(input logic [imucd_pkg::TimeW-1:0] stamp);
        return mk(big_axis(), spread(8000), spread(600), spread(32767), spread(32767),
                  spread(32767), stamp);
    endfunction

    function automatic t_imu_sample level_sample(input logic [imucd_pkg::TimeW-1:0] stamp);
        return mk(spread(1500), spread(1500), big_axis(), spread(32767), spread(32767),
                  spread(32767), stamp);
    endfunction

    function automatic t_imu_sample noise_sample(input logic [imucd_pkg::TimeW-1:0] stamp);
        return mk($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  stamp);
    endfunction

    task automatic send(input t_imu_sample s);
        while ($urandom_range(99) < snd_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        accel_x <= s.ax;
        accel_y <= s.ay;
        accel_z <= s.az;
        gyro_x  <= s.gx;
        gyro_y  <= s.gy;
        gyro_z  <= s.gz;
        now_ms  <= s.stamp;
        @(posedge clk);
        while (full) @(posedge clk);
        samples_sent++;
    endtask

    // Stop offering samples until every predicted result beat has been popped.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic configure(input imucd_pkg::t_cfg c);
        logic [imucd_pkg::CfgDataW-1:0] vals [7];
        vals[0] = imucd_pkg::CfgDataW'(c.impact_mag_sq);
        vals[1] = imucd_pkg::CfgDataW'(c.rotation_mag_sq);
        vals[2] = imucd_pkg::CfgDataW'(c.tilt_cos_sq_q16);
        vals[3] = imucd_pkg::CfgDataW'(c.confirm_win_ms);
        vals[4] = imucd_pkg::CfgDataW'(c.streak_hold_ms);
        vals[5] = imucd_pkg::CfgDataW'(c.grace_win_ms);
        vals[6] = imucd_pkg::CfgDataW'(c.blink_period_ms);
        settle();
        for (int i = 0; i < 7; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= imucd_pkg::t_cfg_idx'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic imucd_pkg::t_cfg short_windows();
        imucd_pkg::t_cfg c;
        c.impact_mag_sq   = $urandom_range(0, 32'h7000_0000);
        c.rotation_mag_sq = $urandom_range(0, 32'h7000_0000);
        c.tilt_cos_sq_q16 = 17'($urandom_range(1500, 40000));
        c.confirm_win_ms  = 16'($urandom_range(60, 400));
        c.streak_hold_ms  = ($urandom_range(3) == 0) ? '0 : 16'($urandom_range(1, 60));
        c.grace_win_ms    = 16'($urandom_range(30, 300));
        c.blink_period_ms = 16'($urandom_range(0, 30));
        return c;
    endfunction

    function automatic imucd_pkg::t_cfg fixed_cfg(input logic [imucd_pkg::MagW-1:0] mag,
                                                  input logic [imucd_pkg::CosW-1:0] cos_sq,
                                                  input logic [imucd_pkg::WinW-1:0] confirm,
                                                  input logic [imucd_pkg::WinW-1:0] others);
        imucd_pkg::t_cfg c;
        c.impact_mag_sq   = mag;
        c.rotation_mag_sq = mag;
        c.tilt_cos_sq_q16 = cos_sq;
        c.confirm_win_ms  = confirm;
        c.streak_hold_ms  = others;
        c.grace_win_ms    = others;
        c.blink_period_ms = others;
        return c;
    endfunction

    // Each episode opens with an impact and follows with mostly tilted samples.
    task automatic run_episodes(input int count, input int step_cap);
        int done;
        int len;
        int pick;
        logic [imucd_pkg::TimeW-1:0] t;
        done = 0;
        while (done < count) begin
            if ($urandom_range(3) == 0) t = 32'hFFFF_FFFF - $urandom_range(0, 20 * step_cap);
            else t = $urandom();
            send(hit_sample(t));
            done++;
            len = $urandom_range(4, 40);
            for (int k = 0; k < len && done < count; k++) begin
                t += $urandom_range(0, step_cap);
                pick = $urandom_range(99);
                if (pick < 55) send(tilt_sample(t));
                else if (pick < 70) send(level_sample(t));
                else if (pick < 82) send(hit_sample(t));
                else if (pick < 97) send(noise_sample(pick < 92 ? t : $urandom()));
                else send(mk(-32768, -32768, -32768, -32768, -32768, -32768, t));
                done++;
            end
        end
    endtask

    initial begin : stimulus
        imucd_pkg::t_cfg c;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass with the power-on register values.
        send(mk(0, 0, 0, 0, 0, 0, 0));                        // accel floor, no impact
        send(mk(32767, 32767, 32767, 32767, 32767, 32767, 32'hFFFF_FFFF));
        send(mk(-32768, -32768, -32768, -32768, -32768, -32768, 5)); // wrapped elapsed
        send(mk(32767, 0, 0, 0, 0, 0, 10));                   // streak begins
        send(mk(32767, 0, 0, 0, 0, 0, 5009));
        send(mk(-32768, 0, 1, 0, 0, 0, 5010));                // snapshot, into grace
        send(mk(0, 0, 0, 0, 0, 0, 5309));
        send(mk(0, 0, 0, 0, 0, 0, 5310));                     // first LED toggle
        send(mk(0, 0, 0, 0, 0, 0, 35009));
        send(mk(0, 0, 0, 0, 0, 0, 35010));                    // alert
        send(mk(20000, 20000, 20000, 30000, 30000, -30000, 100000));
        send(mk(0, 0, 16384, 0, 0, 0, 109999));
        send(mk(0, 0, 16384, 0, 0, 0, 110000));               // confirm window runs out
        send(mk(20000, -20000, 20000, -30000, 30000, 30000, 200000));
        send(mk(0, 32767, -5, 0, 0, 0, 200001));
        send(mk(0, 32767, -5, 0, 0, 0, 210000));              // snapshot and expiry together
        send(mk(-20000, 20000, -20000, 30000, -30000, 30000, 300000));
        send(mk(32767, 0, 3, 0, 0, 0, 300001));
        send(mk(0, 0, 16384, 0, 0, 0, 300002));               // upright breaks the streak
        send(mk(32767, 0, 3, 0, 0, 0, 304000));
        send(mk(32767, 0, 3, 0, 0, 0, 308999));
        send(mk(32767, 0, 3, 0, 0, 0, 309000));
        send(mk(32767, 32767, 32767, -32768, -32768, -32768, 309000));

        // Result side stalls long enough to back the queue up into the input.
        hold_asks <= hold_asks + 1;
        run_episodes(110, 1500);

        configure(short_windows());
        run_episodes(60, 20);
        configure(short_windows());
        run_episodes(60, 20);

        snd_idle_pct <= 74;
        rcv_idle_pct <= 25;
        configure(fixed_cfg('0, 17'd65536, 16'hFFFF, '0));   // everything fires at once
        run_episodes(60, 3);
        configure(fixed_cfg(32'd3221225472, '0, 16'hFFFF, 16'hFFFF));
        run_episodes(30, 1000);
        c = short_windows();
        c.confirm_win_ms = '0;
        configure(c);
        run_episodes(90, 20);

        snd_idle_pct <= 0;
        rcv_idle_pct <= 0;
        configure(short_windows());
        hold_asks <= hold_asks + 1;
        run_episodes(120, 30);

        settle();
        repeat (20) @(posedge clk);
        $display("ran %0d samples under %0d register settings", samples_sent, settings_used);
        $display("model saw %0d snapshot pulses and %0d alert pulses", snapshots, alerts);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> imu_crash_detector.f
hw/rtl/imucd_pkg.sv
hw/rtl/imucd_front.sv
hw/rtl/imucd_fifo.sv
hw/rtl/imucd_back.sv
hw/rtl/imu_crash_detector.sv
tb/imu_crash_checker.sv
tb/imu_crash_detector_test.sv
